/* rtl/rhc_pkg.sv */
// rhc_pkg: shared types and fixed constants of the RGB to HSV converter.
// No dependencies; imported by every module of the block.
package rhc_pkg;

    // Width of the pixel ports, fixed by the interface
    localparam int unsigned CH_PORT_BITS  = 16;
    localparam int unsigned HUE_OUT_BITS  = 15;
    localparam int unsigned SAT_OUT_BITS  = 16;

    // Hue arithmetic in whole degrees
    localparam int unsigned HUE_SECTOR_DEG = 60;
    localparam int unsigned HUE_DEG_FULL   = 360;
    localparam int unsigned HUE_INT_BITS   = 9;   // numerator / diff is at most 420
    localparam int unsigned OFF_BITS       = 9;

    localparam logic [OFF_BITS-1:0] OFF_RED   = 9'd360;
    localparam logic [OFF_BITS-1:0] OFF_GREEN = 9'd120;
    localparam logic [OFF_BITS-1:0] OFF_BLUE  = 9'd240;

    // Saturation is Q0.16; the raw quotient can reach 1.0, hence one more bit
    localparam int unsigned SAT_FRAC_BITS = 16;
    localparam int unsigned SAT_Q_BITS    = SAT_FRAC_BITS + 1;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // Control flags that travel with each request down the chain
    typedef struct packed {
        logic valid;
        logic grey;   // max == min, hue forced to zero
        logic dark;   // max == 0, saturation forced to zero
    } t_cell_ctrl;

    function automatic logic [OFF_BITS-1:0] sector_offset(input t_sector sec);
        logic [OFF_BITS-1:0] off;
        unique case (sec)
            SEC_RED:   off = OFF_RED;
            SEC_GREEN: off = OFF_GREEN;
            SEC_BLUE:  off = OFF_BLUE;
            default:   off = OFF_RED;
        endcase
        return off;
    endfunction

endpackage

/* rtl/rhc_front.sv */
// rhc_front: two-stage front end; finds max/min and the hue sector, then forms
// the difference and the scaled hue numerator. Depends on rhc_pkg.
module rhc_front #(
    parameter int unsigned W = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [W-1:0]                        i_r,
    input  logic [W-1:0]                        i_g,
    input  logic [W-1:0]                        i_b,
    input  logic [rhc_pkg::CH_PORT_BITS-1:0]    i_alpha,
    output rhc_pkg::t_cell_ctrl                 o_ctrl,
    output logic [W-1:0]                        o_mx,
    output logic [W-1:0]                        o_diff,
    output logic [W+8:0]                        o_num,
    output logic [rhc_pkg::CH_PORT_BITS-1:0]    o_alpha
);
    import rhc_pkg::*;

    localparam int unsigned NW = W + 11;

    // stage 1
    t_sector                 n_sec;
    logic [W-1:0]            n_mx;
    logic [W-1:0]            n_mn;
    logic [W-1:0]            n_mn_rg;
    logic signed [W:0]       n_d;

    logic                    r1_valid;
    t_sector                 r1_sec;
    logic [W-1:0]            r1_mx;
    logic [W-1:0]            r1_mn;
    logic signed [W:0]       r1_d;
    logic [CH_PORT_BITS-1:0] r1_alpha;

    // stage 2
    logic [W-1:0]            n_diff;
    logic signed [NW-1:0]    n_num_s;

    always_comb begin
        if (i_r >= i_g && i_r >= i_b) begin
            n_sec = SEC_RED;
        end else if (i_g >= i_b) begin
            n_sec = SEC_GREEN;
        end else begin
            n_sec = SEC_BLUE;
        end

        n_mn_rg = (i_r < i_g) ? i_r : i_g;
        n_mn    = (n_mn_rg < i_b) ? n_mn_rg : i_b;

        unique case (n_sec)
            SEC_RED: begin
                n_mx = i_r;
                n_d  = $signed({1'b0, i_g}) - $signed({1'b0, i_b});
            end
            SEC_GREEN: begin
                n_mx = i_g;
                n_d  = $signed({1'b0, i_b}) - $signed({1'b0, i_r});
            end
            SEC_BLUE: begin
                n_mx = i_b;
                n_d  = $signed({1'b0, i_r}) - $signed({1'b0, i_g});
            end
            default: begin
                n_mx = i_r;
                n_d  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sec   <= n_sec;
            r1_mx    <= n_mx;
            r1_mn    <= n_mn;
            r1_d     <= n_d;
            r1_alpha <= i_alpha;
        end
    end

    // num = 60*d + offset*diff, always in [60*diff, 420*diff]
    always_comb begin
        n_diff  = r1_mx - r1_mn;
        n_num_s = NW'(r1_d) * NW'(HUE_SECTOR_DEG)
                + $signed(NW'(n_diff)) * $signed(NW'(sector_offset(r1_sec)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctrl <= '0;
        end else if (i_en) begin
            o_ctrl.valid <= r1_valid;
            o_ctrl.grey  <= (n_diff == '0);
            o_ctrl.dark  <= (r1_mx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_mx    <= r1_mx;
            o_diff  <= n_diff;
            o_num   <= n_num_s[W+8:0];
            o_alpha <= r1_alpha;
        end
    end

endmodule

/* rtl/rhc_div_cell.sv */
// rhc_div_cell: one restoring-division step for the hue and saturation
// quotients, registered, passing the pixel on to the next cell. Uses rhc_pkg.
module rhc_div_cell #(
    parameter int unsigned W      = 16,
    parameter int unsigned QH     = 15,
    parameter int unsigned QS     = 17,
    parameter bit          DO_HUE = 1'b1,
    parameter bit          DO_SAT = 1'b1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  rhc_pkg::t_cell_ctrl                 i_ctrl,
    input  logic [W-1:0]                        i_hue_div,
    input  logic [W-1:0]                        i_hue_rem,
    input  logic [QH-1:0]                       i_hue_bits,
    input  logic [QH-1:0]                       i_hue_q,
    input  logic [W-1:0]                        i_sat_div,
    input  logic [W-1:0]                        i_sat_rem,
    input  logic [QS-1:0]                       i_sat_bits,
    input  logic [QS-1:0]                       i_sat_q,
    input  logic [rhc_pkg::CH_PORT_BITS-1:0]    i_alpha,
    output rhc_pkg::t_cell_ctrl                 o_ctrl,
    output logic [W-1:0]                        o_hue_div,
    output logic [W-1:0]                        o_hue_rem,
    output logic [QH-1:0]                       o_hue_bits,
    output logic [QH-1:0]                       o_hue_q,
    output logic [W-1:0]                        o_sat_div,
    output logic [W-1:0]                        o_sat_rem,
    output logic [QS-1:0]                       o_sat_bits,
    output logic [QS-1:0]                       o_sat_q,
    output logic [rhc_pkg::CH_PORT_BITS-1:0]    o_alpha
);
    import rhc_pkg::*;

    logic [W:0]    hue_trial;
    logic          hue_ge;
    logic [W:0]    sat_trial;
    logic          sat_ge;

    logic [W-1:0]  n_hue_rem;
    logic [QH-1:0] n_hue_bits;
    logic [QH-1:0] n_hue_q;
    logic [W-1:0]  n_sat_rem;
    logic [QS-1:0] n_sat_bits;
    logic [QS-1:0] n_sat_q;

    always_comb begin
        hue_trial = {i_hue_rem, i_hue_bits[QH-1]};
        hue_ge    = (hue_trial >= {1'b0, i_hue_div});
        sat_trial = {i_sat_rem, i_sat_bits[QS-1]};
        sat_ge    = (sat_trial >= {1'b0, i_sat_div});

        if (DO_HUE) begin
            n_hue_rem  = hue_ge ? W'(hue_trial - {1'b0, i_hue_div}) : hue_trial[W-1:0];
            n_hue_bits = {i_hue_bits[QH-2:0], 1'b0};
            n_hue_q    = {i_hue_q[QH-2:0], hue_ge};
        end else begin
            n_hue_rem  = i_hue_rem;
            n_hue_bits = i_hue_bits;
            n_hue_q    = i_hue_q;
        end

        if (DO_SAT) begin
            n_sat_rem  = sat_ge ? W'(sat_trial - {1'b0, i_sat_div}) : sat_trial[W-1:0];
            n_sat_bits = {i_sat_bits[QS-2:0], 1'b0};
            n_sat_q    = {i_sat_q[QS-2:0], sat_ge};
        end else begin
            n_sat_rem  = i_sat_rem;
            n_sat_bits = i_sat_bits;
            n_sat_q    = i_sat_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctrl <= '0;
        end else if (i_en) begin
            o_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hue_div  <= i_hue_div;
            o_hue_rem  <= n_hue_rem;
            o_hue_bits <= n_hue_bits;
            o_hue_q    <= n_hue_q;
            o_sat_div  <= i_sat_div;
            o_sat_rem  <= n_sat_rem;
            o_sat_bits <= n_sat_bits;
            o_sat_q    <= n_sat_q;
            o_alpha    <= i_alpha;
        end
    end

endmodule

/* rtl/rgb_to_hsv_converter.sv */
// rgb_to_hsv_converter: top level; front end, chain of division cells and
// the output register. Depends on rhc_pkg, rhc_front and rhc_div_cell.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  pixel in| i_valid / o_stall   | i_red, i_green, i_blue, i_alpha
//  hsv out | o_valid / i_stall   | o_hue, o_saturation, o_brightness, o_alpha_out
//
// One request per clock while no result is held at the output. The pipeline is
// two front-end stages, one cell per quotient bit, one output register.
// The cell count is set by the longer of the two quotients (hue or saturation).
// A held result at the output freezes the whole chain; o_stall rises only then.
// Synchronous reset clears all valid flags; no clearing pass.
module rgb_to_hsv_converter #(
    parameter int unsigned CHANNEL_BITS      = 16,
    parameter int unsigned HUE_FRACTION_BITS = 6
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [rhc_pkg::CH_PORT_BITS-1:0]    i_red,
    input  logic [rhc_pkg::CH_PORT_BITS-1:0]    i_green,
    input  logic [rhc_pkg::CH_PORT_BITS-1:0]    i_blue,
    input  logic [rhc_pkg::CH_PORT_BITS-1:0]    i_alpha,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [rhc_pkg::HUE_OUT_BITS-1:0]    o_hue,
    output logic [rhc_pkg::SAT_OUT_BITS-1:0]    o_saturation,
    output logic [rhc_pkg::CH_PORT_BITS-1:0]    o_brightness,
    output logic [rhc_pkg::CH_PORT_BITS-1:0]    o_alpha_out
);
    import rhc_pkg::*;

    localparam int unsigned W  = CHANNEL_BITS;
    localparam int unsigned F  = HUE_FRACTION_BITS;
    localparam int unsigned QH = HUE_INT_BITS + F;
    localparam int unsigned QS = SAT_Q_BITS;
    localparam int unsigned L  = (QH > QS) ? QH : QS;

    localparam logic [QH-1:0] HUE_FULL = QH'(HUE_DEG_FULL) << F;

    logic                    en;

    t_cell_ctrl              f_ctrl;
    logic [W-1:0]            f_mx;
    logic [W-1:0]            f_diff;
    logic [W+8:0]            f_num;
    logic [CH_PORT_BITS-1:0] f_alpha;

    t_cell_ctrl              c_ctrl     [L+1];
    logic [W-1:0]            c_hue_div  [L+1];
    logic [W-1:0]            c_hue_rem  [L+1];
    logic [QH-1:0]           c_hue_bits [L+1];
    logic [QH-1:0]           c_hue_q    [L+1];
    logic [W-1:0]            c_sat_div  [L+1];
    logic [W-1:0]            c_sat_rem  [L+1];
    logic [QS-1:0]           c_sat_bits [L+1];
    logic [QS-1:0]           c_sat_q    [L+1];
    logic [CH_PORT_BITS-1:0] c_alpha    [L+1];

    logic [QH-1:0]           hue_q;
    logic [QS-1:0]           sat_q;
    logic [HUE_OUT_BITS-1:0] n_hue;
    logic [SAT_OUT_BITS-1:0] n_sat;

    logic                    r_out_valid;
    logic [HUE_OUT_BITS-1:0] r_hue;
    logic [SAT_OUT_BITS-1:0] r_sat;
    logic [CH_PORT_BITS-1:0] r_bright;
    logic [CH_PORT_BITS-1:0] r_alpha;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = r_out_valid && i_stall;

    rhc_front #(.W(W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_r     (W'(i_red)),
        .i_g     (W'(i_green)),
        .i_b     (W'(i_blue)),
        .i_alpha (i_alpha),
        .o_ctrl  (f_ctrl),
        .o_mx    (f_mx),
        .o_diff  (f_diff),
        .o_num   (f_num),
        .o_alpha (f_alpha)
    );

    // Hue: quotient of (num << F) / diff fits QH bits, so the top part of the
    // dividend starts as the remainder and the low QH bits are shifted in.
    // Saturation: (diff << 16) / max, 17 quotient bits, same split.
    assign c_ctrl[0]     = f_ctrl;
    assign c_hue_div[0]  = f_diff;
    assign c_hue_rem[0]  = f_num[W+8:HUE_INT_BITS];
    assign c_hue_bits[0] = QH'(f_num[HUE_INT_BITS-1:0]) << F;
    assign c_hue_q[0]    = '0;
    assign c_sat_div[0]  = f_mx;
    assign c_sat_rem[0]  = f_diff >> 1;
    assign c_sat_bits[0] = QS'(f_diff[0]) << SAT_FRAC_BITS;
    assign c_sat_q[0]    = '0;
    assign c_alpha[0]    = f_alpha;

    for (genvar gi = 0; gi < L; gi++) begin : g_cell
        rhc_div_cell #(
            .W      (W),
            .QH     (QH),
            .QS     (QS),
            .DO_HUE (gi < QH),
            .DO_SAT (gi < QS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_en       (en),
            .i_ctrl     (c_ctrl[gi]),
            .i_hue_div  (c_hue_div[gi]),
            .i_hue_rem  (c_hue_rem[gi]),
            .i_hue_bits (c_hue_bits[gi]),
            .i_hue_q    (c_hue_q[gi]),
            .i_sat_div  (c_sat_div[gi]),
            .i_sat_rem  (c_sat_rem[gi]),
            .i_sat_bits (c_sat_bits[gi]),
            .i_sat_q    (c_sat_q[gi]),
            .i_alpha    (c_alpha[gi]),
            .o_ctrl     (c_ctrl[gi+1]),
            .o_hue_div  (c_hue_div[gi+1]),
            .o_hue_rem  (c_hue_rem[gi+1]),
            .o_hue_bits (c_hue_bits[gi+1]),
            .o_hue_q    (c_hue_q[gi+1]),
            .o_sat_div  (c_sat_div[gi+1]),
            .o_sat_rem  (c_sat_rem[gi+1]),
            .o_sat_bits (c_sat_bits[gi+1]),
            .o_sat_q    (c_sat_q[gi+1]),
            .o_alpha    (c_alpha[gi+1])
        );
    end

    always_comb begin
        hue_q = c_hue_q[L];
        sat_q = c_sat_q[L];

        // wrap the red sector back into [0, 360)
        if (c_ctrl[L].grey) begin
            n_hue = '0;
        end else if (hue_q >= HUE_FULL) begin
            n_hue = HUE_OUT_BITS'(hue_q - HUE_FULL);
        end else begin
            n_hue = HUE_OUT_BITS'(hue_q);
        end

        if (c_ctrl[L].dark) begin
            n_sat = '0;
        end else if (sat_q[QS-1]) begin
            n_sat = '1;
        end else begin
            n_sat = sat_q[SAT_OUT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= c_ctrl[L].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hue    <= n_hue;
            r_sat    <= n_sat;
            r_bright <= CH_PORT_BITS'(c_sat_div[L]);
            r_alpha  <= c_alpha[L];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;
    assign o_alpha_out  = r_alpha;

endmodule

/* rtl/rhc_checker.sv */
// rhc_checker: port-level assertions for rgb_to_hsv_converter, bound to it.
// Depends on rhc_pkg and on the top level's port names.
module rhc_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic [rhc_pkg::HUE_OUT_BITS-1:0]    o_hue,
    input logic [rhc_pkg::SAT_OUT_BITS-1:0]    o_saturation,
    input logic [rhc_pkg::CH_PORT_BITS-1:0]    o_brightness,
    input logic [rhc_pkg::CH_PORT_BITS-1:0]    o_alpha_out
);
    import rhc_pkg::*;

    // a held result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hue) && $stable(o_saturation)
                               && $stable(o_brightness) && $stable(o_alpha_out))
        else $error("output request changed while stalled");

    // upstream is only held off while a result waits downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held output");

    // no request leaves the block in the cycle after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // a black pixel has no saturation
    a_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_brightness == '0 |-> o_saturation == '0)
        else $error("nonzero saturation for zero value");

    // a coloured pixel (nonzero hue) has max > min, so saturation is nonzero
    a_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hue != '0 |-> o_saturation != '0)
        else $error("hue present with zero saturation");

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (.*);
